// File: rtl/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg - shared types for the sliding-window median block
// Sequencer states, shared-unit control and flag records, field widths.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int COST_W   = 40;
  localparam int WS_W     = 9;

  localparam logic [WS_W-1:0] WS_RESET = 9'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RING_RD,
    S_RING_WR,
    S_RM,
    S_INS,
    S_INS_LOW,
    S_MED_RD,
    S_MED_WAIT,
    S_COST,
    S_DONE
  } swm_state_t;

  typedef struct packed {
    logic clr;
    logic add;
  } alu_ctl_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } alu_flags_t;

endpackage : swm_pkg
`default_nettype wire

// File: rtl/swm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_if - item channels of the sliding-window median block
// Sample input, median/cost result and window size write channels.
// ----------------------------------------------------------------------------
interface swm_in_if
  import swm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface : swm_in_if

interface swm_out_if
  import swm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] median;
  logic [COST_W-1:0]   cost;

  modport source (output valid, output median, output cost, input ready);
  modport sink   (input valid, input median, input cost, output ready);
endinterface : swm_out_if

interface swm_cfg_if
  import swm_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [WS_W-1:0] window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface : swm_cfg_if
`default_nettype wire

// File: rtl/swm_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_alu - shared compare / absolute difference / accumulate unit
// One unit serves equality and order tests and the cost sum.
// ----------------------------------------------------------------------------
module swm_alu
  import swm_pkg::*;
#(
  parameter int SW = 32
) (
  input  wire logic              clk,
  input  wire logic [SW-1:0]     op_a,
  input  wire logic [SW-1:0]     op_b,
  input  wire alu_ctl_t          ctl,
  output      alu_flags_t        flags,
  output      logic [COST_W-1:0] acc
);

  logic [SW-1:0]     diff;
  logic [COST_W-1:0] acc_r;
  logic [COST_W-1:0] acc_nxt;

  always_comb begin
    flags.gt = op_a > op_b;
    flags.eq = op_a == op_b;
    diff     = flags.gt ? (op_a - op_b) : (op_b - op_a);
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (ctl.add) begin
      acc_nxt = acc_r + COST_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule : swm_alu
`default_nettype wire

// File: rtl/swm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_core - window stores and sequencer
// Holds the arrival ring and sorted copy, removes the oldest sample when full,
// inserts the new one and, if full, reads the median and sums the absolute deviations.
// ----------------------------------------------------------------------------
module swm_core
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX = 256,
  parameter int SW         = 32,
  parameter int KW         = 9
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [KW-1:0]     k,
  input  wire logic              clr_win,
  input  wire logic              in_valid,
  input  wire logic [SW-1:0]     in_sample,
  output      logic              in_ready,
  output      logic              res_valid,
  input  wire logic              res_ready,
  output      logic [SW-1:0]     res_median,
  output      logic [COST_W-1:0] res_cost
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  swm_state_t state_r, state_nxt;

  logic [SW-1:0] ring_mem [WINDOW_MAX];
  logic [SW-1:0] srt_mem  [WINDOW_MAX];

  logic [KW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [KW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [SW-1:0] old_r, old_nxt;
  logic [SW-1:0] med_r, med_nxt;

  logic          ring_we, ring_re;
  logic [SW-1:0] ring_rdata_r;

  logic          srt_re, srt_we;
  logic [AW-1:0] srt_raddr, srt_waddr;
  logic [SW-1:0] srt_wdata;
  logic          srt_rvld_r;
  logic [AW-1:0] srt_raddr_r;
  logic [SW-1:0] srt_rdata_r;

  logic          full;
  logic          last_rd;
  logic [AW-1:0] wp_eff;
  logic [KW-1:0] wp_inc;
  logic [AW-1:0] mid;

  logic [SW-1:0] alu_b;
  alu_ctl_t      alu_ctl;
  alu_flags_t    alu_flags;

  always_comb begin
    full    = fill_r >= k;
    last_rd = KW'(srt_raddr_r) == (k - KW'(1));
    wp_eff  = (KW'(wp_r) >= k) ? '0 : wp_r;
    wp_inc  = KW'(wp_eff) + KW'(1);
    mid     = AW'(((KW'(k) + KW'(1)) >> 1) - KW'(1));
  end

  swm_alu #(
    .SW (SW)
  ) u_alu (
    .clk   (clk),
    .op_a  (srt_rdata_r),
    .op_b  (alu_b),
    .ctl   (alu_ctl),
    .flags (alu_flags),
    .acc   (res_cost)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_RING_RD;
      end
      S_RING_RD: begin
        state_nxt = S_RING_WR;
      end
      S_RING_WR: begin
        state_nxt = full ? S_RM : S_INS;
      end
      S_RM: begin
        if (srt_rvld_r && last_rd) state_nxt = S_INS;
      end
      S_INS: begin
        if (srt_rvld_r) begin
          if (!alu_flags.gt) begin
            state_nxt = S_MED_RD;
          end else if (srt_raddr_r == '0) begin
            state_nxt = S_INS_LOW;
          end
        end else if (idx_r == '0) begin
          state_nxt = S_MED_RD;
        end
      end
      S_INS_LOW: begin
        state_nxt = S_MED_RD;
      end
      S_MED_RD: begin
        state_nxt = full ? S_MED_WAIT : S_IDLE;
      end
      S_MED_WAIT: begin
        state_nxt = S_COST;
      end
      S_COST: begin
        if (srt_rvld_r && last_rd) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    ring_we   = 1'b0;
    ring_re   = 1'b0;
    srt_re    = 1'b0;
    srt_raddr = AW'(idx_r);
    srt_we    = 1'b0;
    srt_waddr = '0;
    srt_wdata = s_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    fill_nxt  = fill_r;
    wp_nxt    = wp_r;
    s_nxt     = s_r;
    old_nxt   = old_r;
    med_nxt   = med_r;
    alu_b     = s_r;
    alu_ctl   = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) s_nxt = in_sample;
      end
      S_RING_RD: begin
        ring_re = 1'b1;
      end
      S_RING_WR: begin
        ring_we   = 1'b1;
        old_nxt   = ring_rdata_r;
        wp_nxt    = (wp_inc >= k) ? '0 : AW'(wp_inc);
        found_nxt = 1'b0;
        idx_nxt   = full ? '0 : fill_r;
        fill_nxt  = full ? fill_r : (fill_r + KW'(1));
      end
      S_RM: begin
        alu_b     = old_r;
        srt_re    = idx_r < k;
        srt_raddr = AW'(idx_r);
        if (srt_re) idx_nxt = idx_r + KW'(1);
        if (srt_rvld_r) begin
          if (found_r) begin
            srt_we    = 1'b1;
            srt_waddr = srt_raddr_r - AW'(1);
            srt_wdata = srt_rdata_r;
          end else if (alu_flags.eq) begin
            found_nxt = 1'b1;
          end
          if (last_rd) idx_nxt = k - KW'(1);
        end
      end
      S_INS: begin
        alu_b     = s_r;
        srt_re    = idx_r != '0;
        srt_raddr = AW'(idx_r - KW'(1));
        if (srt_re) idx_nxt = idx_r - KW'(1);
        if (srt_rvld_r) begin
          srt_we    = 1'b1;
          srt_waddr = srt_raddr_r + AW'(1);
          srt_wdata = alu_flags.gt ? srt_rdata_r : s_r;
        end else if (idx_r == '0) begin
          srt_we    = 1'b1;
          srt_waddr = '0;
        end
      end
      S_INS_LOW: begin
        srt_we    = 1'b1;
        srt_waddr = '0;
      end
      S_MED_RD: begin
        srt_re    = full;
        srt_raddr = mid;
      end
      S_MED_WAIT: begin
        med_nxt     = srt_rdata_r;
        idx_nxt     = '0;
        alu_ctl.clr = 1'b1;
      end
      S_COST: begin
        alu_b       = med_r;
        srt_re      = idx_r < k;
        srt_raddr   = AW'(idx_r);
        if (srt_re) idx_nxt = idx_r + KW'(1);
        alu_ctl.add = srt_rvld_r;
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
    if (clr_win) begin
      fill_nxt = '0;
      wp_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      wp_r       <= '0;
      found_r    <= 1'b0;
      srt_rvld_r <= 1'b0;
      med_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      wp_r       <= wp_nxt;
      found_r    <= found_nxt;
      srt_rvld_r <= srt_re;
      med_r      <= med_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    s_r         <= s_nxt;
    old_r       <= old_nxt;
    srt_raddr_r <= srt_raddr;
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[wp_eff] <= s_r;
    if (ring_re) ring_rdata_r <= ring_mem[wp_eff];
  end

  always_ff @(posedge clk) begin
    if (srt_we) srt_mem[srt_waddr] <= srt_wdata;
    if (srt_re) srt_rdata_r <= srt_mem[srt_raddr];
  end

  assign res_median = med_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= k)
    else $error("fill count beyond window size");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    KW'(wp_r) < k)
    else $error("ring pointer beyond window size");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_RING_RD)
    else $error("accepted item did not start ring read");

  a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> in_ready)
    else $error("not ready after result handed over");

endmodule : swm_core
`default_nettype wire

// File: rtl/sliding_window_median_cost.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_median_cost - sliding-window median and deviation sum
// Keeps the last K samples and, once K have arrived, gives per sample the
// lower median of the window and the sum of absolute deviations from it.
// ----------------------------------------------------------------------------
// One sample is taken at a time; in_ch.ready is low while it is processed.
// The sorted copy sits in a memory with one read and one write per cycle,
// and every pass over it runs one entry a cycle, so that port sets the rate.
// While the window fills, a sample is only inserted; the sample that
// completes the window also has its median read and its cost summed; once
// it is full, each sample passes through removal, insertion and the cost
// sum, and the result may wait for the output register to free.
// A finished result waits in the output register while the next sample is
// taken. Writing window_size empties the window; no clearing pass is needed.
module sliding_window_median_cost
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  swm_in_if.sink     in_ch,
  swm_out_if.source  out_ch,
  swm_cfg_if.sink    cfg_ch
);

  localparam int KW = $clog2(WINDOW_MAX + 1);

  logic [WS_W-1:0]        ws_r;
  logic [KW-1:0]          k;
  logic                   cfg_wr;

  logic                   res_valid;
  logic                   res_ready;
  logic [SAMPLE_BITS-1:0] res_median;
  logic [COST_W-1:0]      res_cost;

  logic                   out_vld_r;
  logic [SAMPLE_W-1:0]    out_med_r;
  logic [COST_W-1:0]      out_cost_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= WS_RESET;
    end else if (cfg_wr) begin
      ws_r <= cfg_ch.window_size;
    end
  end

  // clamp window size to one .. WINDOW_MAX
  always_comb begin
    if (ws_r == '0) begin
      k = KW'(1);
    end else if (32'(ws_r) > 32'(WINDOW_MAX)) begin
      k = KW'(WINDOW_MAX);
    end else begin
      k = KW'(ws_r);
    end
  end

  swm_core #(
    .WINDOW_MAX (WINDOW_MAX),
    .SW         (SAMPLE_BITS),
    .KW         (KW)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .k          (k),
    .clr_win    (cfg_wr),
    .in_valid   (in_ch.valid),
    .in_sample  (in_ch.sample[SAMPLE_BITS-1:0]),
    .in_ready   (in_ch.ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_median (res_median),
    .res_cost   (res_cost)
  );

  assign res_ready = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_ready) begin
      out_vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_med_r  <= SAMPLE_W'(res_median);
      out_cost_r <= res_cost;
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.median = out_med_r;
  assign out_ch.cost   = out_cost_r;

endmodule : sliding_window_median_cost
`default_nettype wire
